// ----- rtl/core/epd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_pkg
// shared types and codes of the escaped packet deframer
// ----------------------------------------------------------------------------
package epd_pkg;

   localparam int ByteWidth      = 8;
   localparam int CsrIndexWidth  = 1;
   localparam int ReqDataWidth   = 8;
   localparam int RspDataWidth   = 24;
   localparam int RspUserWidth   = 1;

   localparam logic [ByteWidth-1:0] StartCodeReset  = 8'd126;
   localparam logic [ByteWidth-1:0] EscapeCodeReset = 8'd125;

   // register indexes of the configuration port
   localparam logic [CsrIndexWidth-1:0] CSR_START_CODE  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_ESCAPE_CODE = 1'b1;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_LENGTH,
      PH_DATA,
      PH_CHECK
   } phase_type;

   typedef struct packed {
      logic                 kind;
      logic [ByteWidth-1:0] payload_byte;
      logic [ByteWidth-1:0] payload_position;
      logic                 frame_good;
   } result_type;

   typedef struct packed {
      logic [ByteWidth-1:0] start_code;
      logic [ByteWidth-1:0] escape_code;
   } codes_type;

endpackage

// ----- rtl/core/escaped_packet_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_packet_deframer
// byte-stuffed frame receiver with xor checksum, payload streamed as it arrives
// ----------------------------------------------------------------------------
// path: a byte lands in the input register; its result, if any, is loaded into
// the result register as the byte advances, which waits while that register is full
// throughput: one byte per cycle, but a byte with a result waits on a stalled receiver
// reset: synchronous, active high; clears frame state and loads start code
// 126 and escape code 125
// ----------------------------------------------------------------------------
module escaped_packet_deframer (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: rx_byte[7:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [epd_pkg::ReqDataWidth-1:0]  req_tdata,
   // tdata: payload_byte[7:0], payload_position[15:8], frame_good[16], zero pad
   // tuser: kind[0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [epd_pkg::RspDataWidth-1:0]  rsp_tdata,
   output logic [epd_pkg::RspUserWidth-1:0]  rsp_tuser,
   input  logic                              csr_we,
   input  logic [epd_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [epd_pkg::ByteWidth-1:0]     csr_wdata
);
   import epd_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 advance;
   logic                 can_take;
   logic                 res_valid;
   result_type           res;
   codes_type            codes;

   // a byte with no result never waits on the output side
   assign advance    = in_valid_ff && (!res_valid || can_take);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_byte_ff <= req_tdata[ByteWidth-1:0];
   end

   epd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .codes     (codes)
   );

   epd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rx_byte   (in_byte_ff),
      .codes     (codes),
      .res_valid (res_valid),
      .res       (res)
   );

   epd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res_valid),
      .res        (res),
      .can_take   (can_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/core/epd_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_csr
// start and escape code registers behind the plain write port
// ----------------------------------------------------------------------------
module epd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [epd_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [epd_pkg::ByteWidth-1:0]       csr_wdata,
   output epd_pkg::codes_type                  codes
);
   import epd_pkg::*;

   codes_type codes_ff;
   codes_type codes_in;

   always_comb begin
      codes_in = codes_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_START_CODE:  codes_in.start_code  = csr_wdata;
            CSR_ESCAPE_CODE: codes_in.escape_code = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.start_code  <= StartCodeReset;
         codes_ff.escape_code <= EscapeCodeReset;
      end else begin
         codes_ff <= codes_in;
      end
   end

   assign codes = codes_ff;

endmodule

// ----- rtl/core/epd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_parser
// unstuffing and frame state machine, one byte per advance
// ----------------------------------------------------------------------------
module epd_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [epd_pkg::ByteWidth-1:0] rx_byte,
   input  epd_pkg::codes_type            codes,
   output logic                          res_valid,
   output epd_pkg::result_type           res
);
   import epd_pkg::*;

   phase_type            phase_ff, phase_in;
   logic                 escape_ff, escape_in;
   logic [ByteWidth-1:0] length_ff, length_in;
   logic [ByteWidth-1:0] count_ff, count_in;
   logic [ByteWidth-1:0] check_ff, check_in;
   logic [ByteWidth-1:0] count_next;

   assign count_next = count_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      escape_in = escape_ff;
      length_in = length_ff;
      count_in  = count_ff;
      check_in  = check_ff;
      res_valid = 1'b0;
      res       = '0;
      if (!escape_ff && rx_byte == codes.escape_code) begin
         escape_in = 1'b1;
      end else if (!escape_ff && rx_byte == codes.start_code) begin
         phase_in = PH_LENGTH;
      end else begin
         escape_in = 1'b0;
         unique case (phase_ff)
            PH_LENGTH: begin
               length_in = rx_byte;
               count_in  = '0;
               check_in  = rx_byte;
               phase_in  = (rx_byte == '0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               if (count_ff < length_ff) begin
                  res_valid            = 1'b1;
                  res.kind             = KIND_PAYLOAD;
                  res.payload_byte     = rx_byte;
                  res.payload_position = count_ff;
                  check_in             = check_ff ^ rx_byte;
                  count_in             = count_next;
                  if (count_next >= length_ff) phase_in = PH_CHECK;
               end else begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               res_valid      = 1'b1;
               res.kind       = KIND_VERDICT;
               res.frame_good = (rx_byte == check_ff);
               phase_in       = PH_WAIT;
            end
            default: phase_in = PH_WAIT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         escape_ff <= 1'b0;
         length_ff <= '0;
         count_ff  <= '0;
         check_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         escape_ff <= escape_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         check_ff  <= check_in;
      end
   end

endmodule

// ----- rtl/core/epd_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_out_stage
// result register driving the master-side stream
// ----------------------------------------------------------------------------
module epd_out_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  epd_pkg::result_type                 res,
   output logic                                can_take,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [epd_pkg::RspDataWidth-1:0]    rsp_tdata,
   output logic [epd_pkg::RspUserWidth-1:0]    rsp_tuser
);
   import epd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign can_take = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load)            valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, res_ff.frame_good, res_ff.payload_position, res_ff.payload_byte};
   assign rsp_tuser  = res_ff.kind;

endmodule

// ----- rtl/core/epd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epd_checker
// port-level checks of the deframer streams, bound to the top level
// ----------------------------------------------------------------------------
module epd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // payload beats never carry a verdict, verdict beats carry no byte or position, pad is zero
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] ? (rsp_tdata[15:0] == 16'd0) : !rsp_tdata[16])
                     && (rsp_tdata[23:17] == 7'd0))
      else $error("result beat fields inconsistent with kind");

   // input side is never blocked while the result register is empty
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat shown right after reset");

endmodule

bind escaped_packet_deframer epd_checker u_epd_checker (.*);

// ----- test/escaped_packet_deframer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_packet_deframer_test
// drives escaped byte streams into the deframer and checks every result beat
// against a cycle-free model of the parser kept in a small scoreboard class;
// covers directed corner frames, random framed traffic with noise and broken
// frames, several start/escape code settings and a long receiver stall
// ----------------------------------------------------------------------------
module escaped_packet_deframer_test;
   import epd_pkg::*;

   class deframe_tracker;
      logic [ByteWidth-1:0] start_code;
      logic [ByteWidth-1:0] escape_code;
      logic                 escaped;
      phase_type            phase;
      logic [ByteWidth-1:0] frame_len;
      logic [ByteWidth-1:0] count;
      logic [ByteWidth-1:0] xor_sum;
      result_type           expected_beats[$];
      int                   mismatches;

      function new();
         start_code  = StartCodeReset;
         escape_code = EscapeCodeReset;
         escaped     = 1'b0;
         phase       = PH_WAIT;
         frame_len   = '0;
         count       = '0;
         xor_sum     = '0;
         mismatches  = 0;
      endfunction

      function void set_code(logic [CsrIndexWidth-1:0] idx, logic [ByteWidth-1:0] value);
         if (idx == CSR_START_CODE) begin
            start_code = value;
         end else begin
            escape_code = value;
         end
      endfunction

      function void note_byte(logic [ByteWidth-1:0] b);
         result_type r;
         if (escaped) begin
            escaped = 1'b0;
         end else if (b == escape_code) begin
            escaped = 1'b1;
            return;
         end else if (b == start_code) begin
            // also abandons any frame in progress
            phase = PH_LENGTH;
            return;
         end
         case (phase)
            PH_LENGTH: begin
               frame_len = b;
               count     = '0;
               xor_sum   = b;
               phase     = (b == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
               if (count < frame_len) begin
                  r = '{kind: KIND_PAYLOAD, payload_byte: b, payload_position: count,
                        frame_good: 1'b0};
                  expected_beats.push_back(r);
                  xor_sum = xor_sum ^ b;
                  count   = count + 8'd1;
               end
               if (count >= frame_len) phase = PH_CHECK;
            end
            PH_CHECK: begin
               r = '{kind: KIND_VERDICT, payload_byte: 8'd0, payload_position: 8'd0,
                     frame_good: (b == xor_sum)};
               expected_beats.push_back(r);
               phase = PH_WAIT;
            end
            default: begin
               phase = PH_WAIT;
            end
         endcase
      endfunction

      function void compare_field(string name, logic [ByteWidth-1:0] want,
                                  logic [ByteWidth-1:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_beat(logic [RspDataWidth-1:0] data, logic [RspUserWidth-1:0] user);
         result_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none actual tdata %h tuser %h",
                     $time, data, user);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         compare_field("kind", 8'(want.kind), 8'(user[0]));
         compare_field("payload_byte", want.payload_byte, data[7:0]);
         compare_field("payload_position", want.payload_position, data[15:8]);
         compare_field("frame_good", 8'(want.frame_good), 8'(data[16]));
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   localparam int TimeoutCycles = 200000;
   localparam int HoldCycles    = 300;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic [RspUserWidth-1:0]  rsp_tuser;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [ByteWidth-1:0]     csr_wdata;

   deframe_tracker       tracker;
   int                   send_idle;
   int                   recv_idle;
   bit                   hold_request;
   int                   hold_left;
   int                   sent;
   logic [ByteWidth-1:0] cur_start;
   logic [ByteWidth-1:0] cur_esc;

   escaped_packet_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // monitor: values read here are the ones sampled by the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) tracker.set_code(csr_index, csr_wdata);
         if (req_tvalid && req_tready) tracker.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_beat(rsp_tdata, rsp_tuser);
      end
   end

   // receiver, with an optional long hold-off
   initial begin
      rsp_tready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   initial begin
      repeat (TimeoutCycles) @(posedge clock);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic logic [ByteWidth-1:0] pick_byte();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? cur_start : cur_esc;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_byte(input logic [ByteWidth-1:0] b);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_stuffed(input logic [ByteWidth-1:0] b);
      if (b == cur_start || b == cur_esc) send_byte(cur_esc);
      send_byte(b);
   endtask

   task automatic send_frame(input int len, input bit corrupt, input bit cut);
      logic [ByteWidth-1:0] sum;
      logic [ByteWidth-1:0] b;
      int                   cut_at;
      sum    = len[7:0];
      cut_at = cut ? $urandom_range(0, len) : len + 1;
      send_byte(cur_start);
      send_stuffed(len[7:0]);
      for (int i = 0; i < len; i++) begin
         if (i == cut_at) return;
         b = pick_byte();
         send_stuffed(b);
         sum = sum ^ b;
      end
      // a cut frame never gets its checksum
      if (cut) return;
      send_stuffed(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   task automatic drain();
      int quiet;
      quiet = 0;
      while (quiet < 6) begin
         @(posedge clock);
         quiet = (tracker.pending() == 0) ? quiet + 1 : 0;
      end
   endtask

   task automatic write_code(input logic [CsrIndexWidth-1:0] idx,
                             input logic [ByteWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_START_CODE) cur_start = value;
      else cur_esc = value;
   endtask

   task automatic run_traffic(input int target);
      int stop_at;
      int pick;
      int len;
      stop_at = sent + target;
      while (sent < stop_at) begin
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         if (pick < 15) begin
            repeat ($urandom_range(1, 4)) send_byte(pick_byte());
         end else begin
            send_frame(len, pick < 28, pick >= 28 && pick < 40);
         end
      end
      req_tvalid <= 1'b0;
      drain();
   endtask

   initial begin
      tracker      = new();
      send_idle    = 8;
      recv_idle    = 49;
      hold_request = 1'b0;
      sent         = 0;
      cur_start    = StartCodeReset;
      cur_esc      = EscapeCodeReset;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_START_CODE;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // noise and an escaped start while waiting: all ignored
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cur_esc);
      send_byte(cur_start);
      // extreme payload values, good checksum
      send_byte(cur_start);
      send_byte(8'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'd2 ^ 8'hFF);
      // empty frames, good then bad
      send_byte(cur_start);
      send_byte(8'd0);
      send_byte(8'd0);
      send_byte(cur_start);
      send_byte(8'd0);
      send_byte(8'h55);
      // stuffed payload bytes equal to the codes
      send_byte(cur_start);
      send_byte(8'd2);
      send_stuffed(cur_start);
      send_stuffed(cur_esc);
      send_stuffed(8'd2 ^ cur_start ^ cur_esc);
      // restart inside a frame, then an escaped ordinary length byte
      send_byte(cur_start);
      send_byte(8'd3);
      send_byte(8'h11);
      send_byte(cur_start);
      send_byte(cur_esc);
      send_byte(8'd1);
      send_byte(8'hAA);
      send_byte(8'd1 ^ 8'hAA);
      req_tvalid <= 1'b0;
      drain();

      run_traffic(100);

      send_idle = 49;
      recv_idle = 8;
      write_code(CSR_START_CODE, 8'h00);
      write_code(CSR_ESCAPE_CODE, 8'hFF);
      run_traffic(100);
      write_code(CSR_START_CODE, 8'hFF);
      write_code(CSR_ESCAPE_CODE, 8'h00);
      run_traffic(40);

      // equal codes: escape wins and no frame ever opens
      write_code(CSR_START_CODE, 8'h42);
      write_code(CSR_ESCAPE_CODE, 8'h42);
      run_traffic(20);

      send_idle = 0;
      recv_idle = 0;
      write_code(CSR_START_CODE, 8'($urandom_range(0, 255)));
      write_code(CSR_ESCAPE_CODE, cur_start ^ 8'($urandom_range(1, 255)));
      // long frame while the receiver holds off, so the input stalls
      hold_request = 1'b1;
      send_frame(60, 1'b0, 1'b0);
      req_tvalid <= 1'b0;
      drain();
      run_traffic(40);

      if (tracker.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
